@@ rtl/assert_macros.svh @@
// Assertion macros shared by the reassembler RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SFR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle, outside reset.
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// Shared constants for the segmented frame reassembler.
// No dependencies; used by the bank RAM and the top level.
package sfr_pkg;

    // Byte and lane geometry of the message store
    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;
    localparam int MAX_CHUNKS = 8;

    // Frame kinds on the input tuser
    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Result kinds on the output tuser
    localparam logic ITEM_STATUS = 1'b0;
    localparam logic ITEM_CHUNK  = 1'b1;

    // Packed stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 104;

endpackage

@@ rtl/sfr_bank_ram.sv @@
// One byte lane of the message store: single write port, single registered read port.
// Depends on sfr_pkg for the byte width.
module sfr_bank_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_wr_data,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [sfr_pkg::BYTE_W-1:0]    o_rd_data
);

    logic [sfr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [sfr_pkg::BYTE_W-1:0] r_rd_data;

    // Write one byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one byte, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/segmented_frame_reassembler.sv @@
// Segmented frame reassembler: a frame's status request is registered in S_EXEC once the
// output register is free; a frame that completes no message then returns to S_IDLE.
// A completing frame then streams its k chunks (one to eight), one row read per chunk
// from the eight byte-lane RAMs (registered read).
// Reset (i_rst_n low, synchronous) clears the sequencer, header and length state;
// the message RAM is not cleared and only written bytes are ever read.
module segmented_frame_reassembler #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input frames
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata from bit 0: priority_req[3], source_addr[8], dest_addr[8], message_type[8],
    //                   sequence_index[8], byte_count[4], payload[64], zero pad[1]
    input  logic [sfr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // tuser: frame_kind[2]
    input  logic [1:0]                     i_s_tuser,
    // Result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata from bit 0: accepted[1], flow_ctrl_send[1], addr_first[8], addr_second[8],
    //                   msg_priority[3], message_code[8], msg_length[7], chunk_data[64], pad[4]
    output logic [sfr_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // tuser: item_kind[1]
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);

    localparam int ROWS   = (BUFFER_BYTES + 7) / 8;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int POS_W  = FILL_W + 1;
    localparam int IDX_W  = (FILL_W > 6) ? FILL_W : 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_DATA = 2'd3;

    // Sequencer and captured request
    logic [1:0]  r_state, n_state;
    logic [1:0]  r_kind;
    logic [2:0]  r_pri;
    logic [7:0]  r_src, r_dst, r_type, r_seq;
    logic [3:0]  r_cnt;
    logic [63:0] r_payload;

    // Reassembly state
    logic              r_long_active, n_long_active;
    logic              r_msg_ready, n_msg_ready;
    logic [7:0]        r_exp_idx, n_exp_idx;
    logic [15:0]       r_rem_len, n_rem_len;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [2:0]        r_hdr_pri, n_hdr_pri;
    logic [7:0]        r_hdr_src, n_hdr_src, r_hdr_dst, n_hdr_dst, r_hdr_type, n_hdr_type;
    logic [2:0]        r_chunk, n_chunk;
    logic [2:0]        r_last_chunk, n_last_chunk;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_user, n_out_user;
    logic                          r_out_last, n_out_last;
    logic [sfr_pkg::M_TDATA_W-1:0] r_out_data, n_out_data;

    // Frame decision
    logic              e_acc, e_fc, e_done, e_append, e_hdr;
    logic              e_long, e_ready;
    logic [7:0]        e_exp;
    logic [15:0]       e_rem, e_rem_sub;
    logic [FILL_W-1:0] e_fill;
    logic [3:0]        n_eff;
    logic [FILL_W-1:0] app_base;
    logic [POS_W-1:0]  fill_sum;
    logic [FILL_W-1:0] fill_after;
    logic [POS_W-1:0]  ch_sum, ch_cnt;
    logic [2:0]        e_last_chunk;

    // Bank ports
    logic [2:0]                  lane     [sfr_pkg::LANES];
    logic [POS_W-1:0]            pos      [sfr_pkg::LANES];
    logic [sfr_pkg::LANES-1:0]   bank_we;
    logic [ROW_W-1:0]            bank_wrow[sfr_pkg::LANES];
    logic [sfr_pkg::BYTE_W-1:0]  bank_wdat[sfr_pkg::LANES];
    logic [sfr_pkg::BYTE_W-1:0]  bank_rdat[sfr_pkg::LANES];
    logic                        rd_en;
    logic [ROW_W-1:0]            rd_row;
    logic [63:0]                 chunk_data;

    logic out_free, exec_go;

    assign out_free   = !r_out_valid || i_m_tready;
    assign exec_go    = (r_state == S_EXEC) && out_free;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = r_out_data;

    // Clamp the byte count and work out where appended bytes land
    always_comb begin
        n_eff      = (r_cnt > 4'd8) ? 4'd8 : r_cnt;
        app_base   = (r_kind == sfr_pkg::KIND_SHORT) ? '0 : r_fill;
        fill_sum   = POS_W'(app_base) + POS_W'(n_eff);
        fill_after = (fill_sum > POS_W'(BUFFER_BYTES)) ? FILL_W'(BUFFER_BYTES)
                                                       : fill_sum[FILL_W-1:0];
        e_rem_sub  = r_rem_len - 16'(n_eff);
    end

    // Decide status and next reassembly state for the captured frame
    always_comb begin
        e_acc    = 1'b1;
        e_fc     = 1'b0;
        e_done   = 1'b0;
        e_append = 1'b0;
        e_hdr    = 1'b0;
        e_long   = r_long_active;
        e_ready  = r_msg_ready;
        e_exp    = r_exp_idx;
        e_rem    = r_rem_len;
        e_fill   = r_fill;
        unique case (r_kind)
            sfr_pkg::KIND_SHORT: begin
                e_long   = 1'b0;
                e_hdr    = 1'b1;
                e_append = 1'b1;
                e_fill   = fill_after;
                e_ready  = 1'b1;
                e_done   = 1'b1;
            end
            sfr_pkg::KIND_FIRST: begin
                e_hdr  = 1'b1;
                e_fill = '0;
                e_exp  = 8'd1;
                e_rem  = r_payload[15:0];
                if (r_payload[15:0] > 16'(BUFFER_BYTES)) begin
                    e_long  = 1'b0;
                    e_ready = 1'b0;
                    e_acc   = 1'b0;
                end else begin
                    e_fc = 1'b1;
                    if (r_payload[15:0] == 16'd0) begin
                        e_long  = 1'b0;
                        e_ready = 1'b1;
                        e_done  = 1'b1;
                    end else begin
                        e_long  = 1'b1;
                        e_ready = 1'b0;
                    end
                end
            end
            sfr_pkg::KIND_NEXT: begin
                if (!r_long_active || r_msg_ready) begin
                    e_acc = 1'b0;
                end else if (r_seq != r_exp_idx || 16'(n_eff) > r_rem_len) begin
                    e_long = 1'b0;
                    e_acc  = 1'b0;
                end else begin
                    e_append = 1'b1;
                    e_fill   = fill_after;
                    e_rem    = e_rem_sub;
                    e_exp    = r_exp_idx + 8'd1;
                    if (e_rem_sub == 16'd0) begin
                        e_long  = 1'b0;
                        e_ready = 1'b1;
                        e_done  = 1'b1;
                    end
                end
            end
            sfr_pkg::KIND_OTHER: begin
            end
            default: begin
            end
        endcase
    end

    // Chunk count: ceil(fill / 8), at least one, at most eight
    always_comb begin
        ch_sum = POS_W'(e_fill) + POS_W'(7);
        ch_cnt = ch_sum >> 3;
        if (ch_cnt == '0) begin
            e_last_chunk = 3'd0;
        end else if (ch_cnt > POS_W'(sfr_pkg::MAX_CHUNKS)) begin
            e_last_chunk = 3'(sfr_pkg::MAX_CHUNKS - 1);
        end else begin
            e_last_chunk = 3'(ch_cnt - POS_W'(1));
        end
    end

    // Rotate payload bytes onto the lanes; a lane below the start lane wraps to the next row
    always_comb begin
        for (int b = 0; b < sfr_pkg::LANES; b++) begin
            lane[b]      = 3'(b) - app_base[2:0];
            pos[b]       = POS_W'(app_base) + POS_W'(lane[b]);
            bank_we[b]   = exec_go && e_append && ({1'b0, lane[b]} < n_eff) &&
                           (pos[b] < POS_W'(BUFFER_BYTES));
            bank_wrow[b] = ROW_W'(pos[b] >> 3);
            bank_wdat[b] = r_payload[8*lane[b] +: 8];
        end
    end

    // Read the first row on entry, then prefetch the next row as each chunk leaves
    assign rd_en  = (r_state == S_RD) ||
                    ((r_state == S_DATA) && out_free && (r_chunk != r_last_chunk));
    assign rd_row = (r_state == S_RD) ? ROW_W'(r_chunk) : ROW_W'(r_chunk + 3'd1);

    // Zero the bytes past the message length
    always_comb begin
        for (int b = 0; b < sfr_pkg::LANES; b++) begin
            if (IDX_W'({r_chunk, 3'(b)}) < IDX_W'(r_fill)) begin
                chunk_data[8*b +: 8] = bank_rdat[b];
            end else begin
                chunk_data[8*b +: 8] = 8'd0;
            end
        end
    end

    // Byte-lane RAMs
    for (genvar g = 0; g < sfr_pkg::LANES; g++) begin : g_bank
        sfr_bank_ram #(
            .DEPTH  (ROWS),
            .ADDR_W (ROW_W)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (bank_we[g]),
            .i_wr_addr (bank_wrow[g]),
            .i_wr_data (bank_wdat[g]),
            .i_rd_en   (rd_en),
            .i_rd_addr (rd_row),
            .o_rd_data (bank_rdat[g])
        );
    end

    // Sequencer: capture, execute with status request, then stream chunks if a message completes
    always_comb begin
        n_state       = r_state;
        n_long_active = r_long_active;
        n_msg_ready   = r_msg_ready;
        n_exp_idx     = r_exp_idx;
        n_rem_len     = r_rem_len;
        n_fill        = r_fill;
        n_hdr_pri     = r_hdr_pri;
        n_hdr_src     = r_hdr_src;
        n_hdr_dst     = r_hdr_dst;
        n_hdr_type    = r_hdr_type;
        n_chunk       = r_chunk;
        n_last_chunk  = r_last_chunk;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_user    = r_out_user;
        n_out_last    = r_out_last;
        n_out_data    = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_long_active = e_long;
                    n_msg_ready   = e_ready;
                    n_exp_idx     = e_exp;
                    n_rem_len     = e_rem;
                    n_fill        = e_fill;
                    if (e_hdr) begin
                        n_hdr_pri  = r_pri;
                        n_hdr_src  = r_src;
                        n_hdr_dst  = r_dst;
                        n_hdr_type = r_type;
                    end
                    n_chunk      = 3'd0;
                    n_last_chunk = e_last_chunk;
                    n_out_valid  = 1'b1;
                    n_out_user   = sfr_pkg::ITEM_STATUS;
                    n_out_last   = !e_done;
                    n_out_data   = {4'd0, 64'd0, 7'd0, 8'd0, 3'd0, r_dst, r_src, e_fc, e_acc};
                    n_state      = e_done ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = sfr_pkg::ITEM_CHUNK;
                    n_out_last  = (r_chunk == r_last_chunk);
                    n_out_data  = {4'd0, chunk_data, 7'(r_fill), r_hdr_type, r_hdr_pri,
                                   r_hdr_dst, r_hdr_src, 1'b0, 1'b0};
                    if (r_chunk == r_last_chunk) begin
                        n_state = S_IDLE;
                    end else begin
                        n_chunk = r_chunk + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_long_active <= 1'b0;
            r_msg_ready   <= 1'b0;
            r_exp_idx     <= 8'd0;
            r_rem_len     <= 16'd0;
            r_fill        <= '0;
            r_hdr_pri     <= 3'd0;
            r_hdr_src     <= 8'd0;
            r_hdr_dst     <= 8'd0;
            r_hdr_type    <= 8'd0;
            r_chunk       <= 3'd0;
            r_last_chunk  <= 3'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_long_active <= n_long_active;
            r_msg_ready   <= n_msg_ready;
            r_exp_idx     <= n_exp_idx;
            r_rem_len     <= n_rem_len;
            r_fill        <= n_fill;
            r_hdr_pri     <= n_hdr_pri;
            r_hdr_src     <= n_hdr_src;
            r_hdr_dst     <= n_hdr_dst;
            r_hdr_type    <= n_hdr_type;
            r_chunk       <= n_chunk;
            r_last_chunk  <= n_last_chunk;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers: captured request and output item
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_kind    <= i_s_tuser;
            r_pri     <= i_s_tdata[2:0];
            r_src     <= i_s_tdata[10:3];
            r_dst     <= i_s_tdata[18:11];
            r_type    <= i_s_tdata[26:19];
            r_seq     <= i_s_tdata[34:27];
            r_cnt     <= i_s_tdata[38:35];
            r_payload <= i_s_tdata[102:39];
        end
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
    end

    `include "assert_macros.svh"

    // A long message in progress is never also a finished one
    `SFR_ASSERT_RST(a_active_ready_excl, !(r_long_active && r_msg_ready), "active and ready")
    // The fill count stays inside the buffer
    `SFR_ASSERT_RST(a_fill_bound, r_fill <= FILL_W'(BUFFER_BYTES), "fill past buffer")
    // A status request without tlast is followed by chunks still being read
    `SFR_ASSERT_IMP(a_status_then_chunks,
        r_out_valid && (r_out_user == sfr_pkg::ITEM_STATUS) && !r_out_last,
        (r_state == S_RD) || (r_state == S_DATA), "status without chunk sequence")
    // No new frame is taken while chunks are pending
    `SFR_ASSERT_IMP(a_no_accept_in_chunks, (r_state == S_RD) || (r_state == S_DATA),
        !o_s_tready, "frame accepted during chunks")

endmodule
